FILE: src/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the height-map bilinear sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  localparam int TABLE_DEPTH  = 4096;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int COORD_W      = 32;
  localparam int FRAC_W       = 16;
  localparam int CNT_W        = 13;
  localparam int IDX_W        = CNT_W;
  localparam int ENTRY_W      = 12;
  localparam int GADDR_W      = 2 * CNT_W;
  localparam int WGT1_W       = FRAC_W + 1;
  localparam int WT_W         = 2 * FRAC_W + 1;
  localparam int PROD_W       = COORD_W + WT_W + 1;
  localparam int ACC_W        = PROD_W + 1;
  localparam int SAMPLE_READS = 4;
  localparam int SEQ_W        = $clog2(SAMPLE_READS);
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = Q_PTR_W + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int OP_W         = 2;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_OOR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_D    = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_z;
    logic [COORD_W-1:0]        inv_step_x;
    logic [COORD_W-1:0]        inv_step_z;
    logic [CNT_W-1:0]          count_x;
    logic [CNT_W-1:0]          count_z;
    logic                      three_d;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]                         op;
    logic [SAMPLE_READS-1:0][ADDR_W-1:0]     addr;
    logic [SAMPLE_READS-1:0]                 in_tab;
    logic [SAMPLE_READS-1:0][WT_W-1:0]       wt;
    logic [COORD_W-1:0]                      wdata;
  } qent_t;

endpackage

`default_nettype wire

FILE: src/hbs_ram.sv
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/hbs_front.sv
// ----------------------------------------------------------------------------
// hbs_front
// Four-stage front: grid position, cell index, clamping, table addresses
// and corner weights of each item, pushed in order into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_front import hbs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  input  logic                      q_full_i,
  input  logic                      req_type_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] z_i,
  input  logic [ENTRY_W-1:0]        entry_index_i,
  input  logic signed [COORD_W-1:0] entry_height_i,
  output logic                      push_o,
  output qent_t                     ent_o
);

  logic en;
  assign en = !q_full_i;

  // stage 1
  logic [COORD_W:0]   rel_x, rel_z;
  logic               s1_vld_q, s1_smp_q, s1_neg_x_q, s1_neg_z_q;
  logic [COORD_W-1:0] s1_mag_x_q, s1_mag_z_q, s1_hgt_q;
  logic [ENTRY_W-1:0] s1_eidx_q;

  assign rel_x = {x_i[COORD_W-1], x_i} - {cfg_i.min_x[COORD_W-1], cfg_i.min_x};
  assign rel_z = {z_i[COORD_W-1], z_i} - {cfg_i.min_z[COORD_W-1], cfg_i.min_z};

  // stage 2
  logic                 s2_vld_q, s2_smp_q, s2_neg_x_q, s2_neg_z_q;
  logic [2*COORD_W-1:0] s2_px_q, s2_pz_q;
  logic [COORD_W-1:0]   s2_hgt_q;
  logic [ENTRY_W-1:0]   s2_eidx_q;

  // stage 3
  logic [COORD_W-1:0] idx_x, idx_z;
  logic [FRAC_W-1:0]  fx, fz;
  logic [CNT_W-1:0]   cm1_x, cm1_z;
  logic               oor_x, oor_z;
  logic [IDX_W-1:0]   i_d, ip_d, k_d, kp_d;
  logic               s3_vld_q, s3_smp_q, s3_oor_q;
  logic [IDX_W-1:0]   s3_i_q, s3_ip_q, s3_k_q, s3_kp_q;
  logic [WGT1_W-1:0]  s3_wx0_q, s3_wx1_q, s3_wz0_q, s3_wz1_q;
  logic [COORD_W-1:0] s3_hgt_q;
  logic [ENTRY_W-1:0] s3_eidx_q;

  always_comb begin
    idx_x = s2_px_q[2*COORD_W-1:COORD_W];
    idx_z = s2_pz_q[2*COORD_W-1:COORD_W];
    fx    = s2_px_q[COORD_W-1:COORD_W-FRAC_W];
    cm1_x = cfg_i.count_x - CNT_W'(1);
    cm1_z = cfg_i.count_z - CNT_W'(1);
    oor_x = s2_neg_x_q || (cfg_i.count_x == '0) || (idx_x > COORD_W'(cm1_x));
    i_d   = idx_x[IDX_W-1:0];
    ip_d  = (i_d == cm1_x) ? i_d : i_d + IDX_W'(1);
    if (cfg_i.three_d) begin
      oor_z = s2_neg_z_q || (cfg_i.count_z == '0) || (idx_z > COORD_W'(cm1_z));
      k_d   = idx_z[IDX_W-1:0];
      kp_d  = (k_d == cm1_z) ? k_d : k_d + IDX_W'(1);
      fz    = s2_pz_q[COORD_W-1:COORD_W-FRAC_W];
    end else begin
      oor_z = 1'b0;
      k_d   = '0;
      kp_d  = '0;
      fz    = '0;
    end
  end

  // stage 4
  logic                              s4_vld_q, s4_smp_q, s4_oor_q;
  logic [GADDR_W-1:0]                s4_r0_q, s4_r1_q;
  logic [IDX_W-1:0]                  s4_i_q, s4_ip_q;
  logic [SAMPLE_READS-1:0][WT_W-1:0] s4_wt_q;
  logic [COORD_W-1:0]                s4_hgt_q;
  logic [ENTRY_W-1:0]                s4_eidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_smp_q   <= req_type_i;
      s1_neg_x_q <= rel_x[COORD_W] && (cfg_i.inv_step_x != '0);
      s1_neg_z_q <= rel_z[COORD_W] && (cfg_i.inv_step_z != '0);
      s1_mag_x_q <= rel_x[COORD_W] ? '0 : rel_x[COORD_W-1:0];
      s1_mag_z_q <= rel_z[COORD_W] ? '0 : rel_z[COORD_W-1:0];
      s1_hgt_q   <= entry_height_i;
      s1_eidx_q  <= entry_index_i;

      s2_smp_q   <= s1_smp_q;
      s2_neg_x_q <= s1_neg_x_q;
      s2_neg_z_q <= s1_neg_z_q;
      s2_px_q    <= (2*COORD_W)'(s1_mag_x_q) * (2*COORD_W)'(cfg_i.inv_step_x);
      s2_pz_q    <= (2*COORD_W)'(s1_mag_z_q) * (2*COORD_W)'(cfg_i.inv_step_z);
      s2_hgt_q   <= s1_hgt_q;
      s2_eidx_q  <= s1_eidx_q;

      s3_smp_q   <= s2_smp_q;
      s3_oor_q   <= oor_x || oor_z;
      s3_i_q     <= i_d;
      s3_ip_q    <= ip_d;
      s3_k_q     <= k_d;
      s3_kp_q    <= kp_d;
      s3_wx0_q   <= WGT1_W'(1 << FRAC_W) - WGT1_W'(fx);
      s3_wx1_q   <= WGT1_W'(fx);
      s3_wz0_q   <= WGT1_W'(1 << FRAC_W) - WGT1_W'(fz);
      s3_wz1_q   <= WGT1_W'(fz);
      s3_hgt_q   <= s2_hgt_q;
      s3_eidx_q  <= s2_eidx_q;

      s4_smp_q   <= s3_smp_q;
      s4_oor_q   <= s3_oor_q;
      s4_r0_q    <= GADDR_W'(cfg_i.count_x) * GADDR_W'(s3_k_q);
      s4_r1_q    <= GADDR_W'(cfg_i.count_x) * GADDR_W'(s3_kp_q);
      s4_i_q     <= s3_i_q;
      s4_ip_q    <= s3_ip_q;
      s4_wt_q[0] <= WT_W'(s3_wx0_q) * WT_W'(s3_wz0_q);
      s4_wt_q[1] <= WT_W'(s3_wx1_q) * WT_W'(s3_wz0_q);
      s4_wt_q[2] <= WT_W'(s3_wx0_q) * WT_W'(s3_wz1_q);
      s4_wt_q[3] <= WT_W'(s3_wx1_q) * WT_W'(s3_wz1_q);
      s4_hgt_q   <= s3_hgt_q;
      s4_eidx_q  <= s3_eidx_q;
    end
  end

  logic [SAMPLE_READS-1:0][GADDR_W-1:0] gaddr;

  always_comb begin
    ent_o.wt    = s4_wt_q;
    ent_o.wdata = s4_hgt_q;
    if (!s4_smp_q) begin
      ent_o.op = OP_WRITE;
      gaddr    = '0;
      gaddr[0] = GADDR_W'(s4_eidx_q);
    end else begin
      ent_o.op = s4_oor_q ? OP_OOR : OP_SAMPLE;
      gaddr[0] = s4_r0_q + GADDR_W'(s4_i_q);
      gaddr[1] = s4_r0_q + GADDR_W'(s4_ip_q);
      gaddr[2] = s4_r1_q + GADDR_W'(s4_i_q);
      gaddr[3] = s4_r1_q + GADDR_W'(s4_ip_q);
    end
    for (int j = 0; j < SAMPLE_READS; j++) begin
      ent_o.addr[j]   = gaddr[j][ADDR_W-1:0];
      ent_o.in_tab[j] = gaddr[j] < GADDR_W'(TABLE_DEPTH);
    end
  end

  assign push_o = en && s4_vld_q;

endmodule

`default_nettype wire

FILE: src/hbs_queue.sv
// ----------------------------------------------------------------------------
// hbs_queue
// Short in-order queue of prepared items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_queue import hbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t ent_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output qent_t head_o
);

  qent_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= ent_i;
    end
  end

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: src/hbs_back.sv
// ----------------------------------------------------------------------------
// hbs_back
// Back end: table writes, four corner reads per sample, weighted
// accumulation, rounding and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_back import hbs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  qent_t                     q_head_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] height_o,
  output logic                      out_of_range_o
);

  localparam logic [SEQ_W-1:0] SEQ_LAST   = SEQ_W'(SAMPLE_READS - 1);
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'h8000_0000);

  logic en_b, issue, out_valid_q;
  assign en_b  = !(out_valid_q && out_stall_i);
  assign issue = en_b && !q_empty_i;

  // issue
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [COORD_W-1:0] ram_rdata;
  logic [SEQ_W-1:0]  cnt_q, cnt_d;
  logic              r_vld_d, r_oor_d, r_first_d, r_last_d, r_tab_d;
  logic [WT_W-1:0]   r_wt_d;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = q_head_i.addr[0];
    q_pop_o   = 1'b0;
    cnt_d     = cnt_q;
    r_vld_d   = 1'b0;
    r_oor_d   = 1'b0;
    r_first_d = 1'b0;
    r_last_d  = 1'b0;
    r_tab_d   = q_head_i.in_tab[cnt_q];
    r_wt_d    = q_head_i.wt[cnt_q];
    if (issue) begin
      case (q_head_i.op)
        OP_WRITE: begin
          ram_we  = q_head_i.in_tab[0];
          q_pop_o = 1'b1;
        end
        OP_SAMPLE: begin
          ram_re    = 1'b1;
          ram_addr  = q_head_i.addr[cnt_q];
          r_vld_d   = 1'b1;
          r_first_d = (cnt_q == '0);
          r_last_d  = (cnt_q == SEQ_LAST);
          q_pop_o   = (cnt_q == SEQ_LAST);
          cnt_d     = (cnt_q == SEQ_LAST) ? '0 : cnt_q + SEQ_W'(1);
        end
        OP_OOR: begin
          r_vld_d   = 1'b1;
          r_oor_d   = 1'b1;
          r_first_d = 1'b1;
          r_last_d  = 1'b1;
          q_pop_o   = 1'b1;
        end
        default: begin
          q_pop_o = 1'b1;
        end
      endcase
    end
  end

  hbs_ram #(
    .WIDTH (COORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (q_head_i.wdata),
    .rdata_o (ram_rdata)
  );

  // read and multiply stages
  logic                      r_vld_q, r_oor_q, r_first_q, r_last_q, r_tab_q;
  logic [WT_W-1:0]           r_wt_q;
  logic signed [COORD_W-1:0] m_data;
  logic                      m_vld_q, m_oor_q, m_first_q, m_last_q;
  logic signed [PROD_W-1:0]  m_prod_q;

  assign m_data = r_tab_q ? $signed(ram_rdata) : '0;

  // accumulate and round
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [ACC_W-1:2*COORD_W-1] acc_top;
  logic [COORD_W-1:0]        hval;
  logic                      load;
  logic signed [COORD_W-1:0] height_q;
  logic                      oor_q;

  always_comb begin
    acc_d   = (m_first_q ? ROUND_BIAS : acc_q) + {m_prod_q[PROD_W-1], m_prod_q};
    acc_top = acc_d[ACC_W-1:2*COORD_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      hval = acc_d[2*COORD_W-1:COORD_W];
    end else if (acc_d[ACC_W-1]) begin
      hval = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      hval = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  assign load = en_b && m_vld_q && (m_oor_q || m_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      r_vld_q     <= 1'b0;
      r_oor_q     <= 1'b0;
      r_first_q   <= 1'b0;
      r_last_q    <= 1'b0;
      m_vld_q     <= 1'b0;
      m_oor_q     <= 1'b0;
      m_first_q   <= 1'b0;
      m_last_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_b) begin
        cnt_q     <= cnt_d;
        r_vld_q   <= r_vld_d;
        r_oor_q   <= r_oor_d;
        r_first_q <= r_first_d;
        r_last_q  <= r_last_d;
        m_vld_q   <= r_vld_q;
        m_oor_q   <= r_oor_q;
        m_first_q <= r_first_q;
        m_last_q  <= r_last_q;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      r_tab_q  <= r_tab_d;
      r_wt_q   <= r_wt_d;
      m_prod_q <= m_data * $signed({1'b0, r_wt_q});
      if (m_vld_q && !m_oor_q) begin
        acc_q <= acc_d;
      end
    end
    if (load) begin
      height_q <= m_oor_q ? '0 : hval;
      oor_q    <= m_oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign height_o       = height_q;
  assign out_of_range_o = oor_q;

`ifndef SYNTHESIS
  a_seq_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (!q_empty_i && q_head_i.op == OP_SAMPLE))
    else $error("read sequence active without a sample at queue head");
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re) else $error("table read and write in one cycle");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_b |-> (!q_pop_o && !ram_we && !ram_re && !load))
    else $error("back end advanced while result stalled");
`endif

endmodule

`default_nettype wire

FILE: src/heightmap_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_core
// Height table with bilinear (x,z) or linear (x) sampling in signed Q16.16.
//
//   channel  dir  handshake              word
//   in       in   in_valid_i/in_stall_o  req_type, x, z, entry_index, height
//   out      out  out_valid_o/out_stall_i height, out_of_range
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A table write is a single issue in the back end; a sample issues its four
// corner reads one after another on the single table port, and an
// out-of-grid sample issues no table read.
// Reset clears control and loads register defaults; the table is not cleared.
// Input stalls only while the four-entry queue is full; a held result stalls
// the back end alone.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_bilinear_sampler_core import hbs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] z_i,
  input  logic [ENTRY_W-1:0]        entry_index_i,
  input  logic signed [COORD_W-1:0] entry_height_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] height_o,
  output logic                      out_of_range_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_W-1:0]        cfg_data_i
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x      <= '0;
      cfg_q.min_z      <= '0;
      cfg_q.inv_step_x <= COORD_W'(1 << FRAC_W);
      cfg_q.inv_step_z <= COORD_W'(1 << FRAC_W);
      cfg_q.count_x    <= CNT_W'(1);
      cfg_q.count_z    <= CNT_W'(1);
      cfg_q.three_d    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_X:      cfg_q.min_x      <= cfg_data_i;
        CFG_MIN_Z:      cfg_q.min_z      <= cfg_data_i;
        CFG_INV_STEP_X: cfg_q.inv_step_x <= cfg_data_i;
        CFG_INV_STEP_Z: cfg_q.inv_step_z <= cfg_data_i;
        CFG_COUNT_X:    cfg_q.count_x    <= cfg_data_i[CNT_W-1:0];
        CFG_COUNT_Z:    cfg_q.count_z    <= cfg_data_i[CNT_W-1:0];
        CFG_THREE_D:    cfg_q.three_d    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic  q_push, q_pop, q_full, q_empty;
  qent_t q_in, q_head;

  assign in_stall_o = q_full;

  hbs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .q_full_i       (q_full),
    .req_type_i     (req_type_i),
    .x_i            (x_i),
    .z_i            (z_i),
    .entry_index_i  (entry_index_i),
    .entry_height_i (entry_height_i),
    .push_o         (q_push),
    .ent_o          (q_in)
  );

  hbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ent_i   (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  hbs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .height_o       (height_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

`default_nettype wire
